### design/l2n_pkg.sv
// Shared types and constants for the embedding L2 normalizer.
// No dependencies; imported by the top level and by l2n_lane.
package l2n_pkg;

   localparam int unsigned LaneCount = 4;
   localparam int unsigned ByteW     = 8;
   localparam int unsigned WordW     = LaneCount * ByteW;
   localparam int unsigned KeyW      = 8;   // width of the scaled result k
   localparam int unsigned SqW       = 16;  // width of a trial squared
   localparam int unsigned TargetW   = 29;  // 16384 * 128 * 128 fits here
   localparam int unsigned ScaleShift = 14; // 128 * 128 = 2**14

   // top-level sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ,
      ST_SETUP,
      ST_SEARCH,
      ST_EMIT
   } state_type;

   // per-bit phases of the lane search
   typedef enum logic [1:0] {
      PH_SQUARE,
      PH_SCALE,
      PH_COMPARE
   } phase_type;

   // start command from sequencer to each lane unit
   typedef struct packed {
      logic               start;
      logic [ByteW-1:0]   element;
   } lane_cmd_type;

endpackage

### design/embedding_l2_normalizer_unit.sv
// Top level of the embedding L2 normalizer: sequencer, word store, four lanes.
// Depends on l2n_pkg, l2n_ram and l2n_lane.
//
// Loads VECTOR_WORDS request words at one per cycle while summing the squares
// of all elements, then emits one normalized response word per stored word.
// Each response word then passes through the word-store read, the start of
// the lanes, the eight-step search of the key k (each step through the
// squaring and scaling multipliers and a compare), the load of the output
// register and the wait for rsp_tready. No request is taken while a vector
// is being emitted. A zero vector yields all-zero bytes.
module embedding_l2_normalizer_unit
   import l2n_pkg::*;
#(
   parameter int unsigned VECTOR_WORDS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // lane0, lane1, lane2, lane3
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // norm0, norm1, norm2, norm3
   output logic        rsp_tlast
);

   localparam int unsigned AddrW = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1;
   localparam int unsigned CntW  = $clog2(VECTOR_WORDS + 1);
   localparam int unsigned SumW  = 17 + $clog2(VECTOR_WORDS);

   state_type          state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [SumW-1:0]    sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WordW-1:0]   rsp_data_ff;
   logic               rsp_last_ff;
   logic               req_fire, rsp_fire;
   logic               rd_en, lanes_start;
   logic [WordW-1:0]   rd_data;
   logic [LaneCount-1:0] lane_done;
   logic [ByteW-1:0]   lane_norm [LaneCount];
   logic [SumW-1:0]    word_sq;
   lane_cmd_type       lane_cmd [LaneCount];

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_valid_ff && rsp_tready;

   // sum of the four squares of the incoming request
   always_comb begin
      logic signed [ByteW-1:0] v;
      word_sq = '0;
      for (int i = 0; i < LaneCount; i++) begin
         v = req_tdata[i*ByteW +: ByteW];
         word_sq = word_sq + SumW'(unsigned'(16'(v * v)));
      end
   end

   // sequencer: load, then read, start, search and emit per word
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_en        = 1'b0;
      lanes_start  = 1'b0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_fire) begin
               sum_in = sum_ff + word_sq;
               if (count_ff == CntW'(VECTOR_WORDS - 1)) begin
                  count_in = '0;
                  state_in = ST_READ;
               end else begin
                  count_in = count_ff + CntW'(1);
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            lanes_start = 1'b1;
            state_in    = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (&lane_done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (count_ff == CntW'(VECTOR_WORDS - 1)) begin
                  count_in = '0;
                  sum_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  count_in = count_ff + CntW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response word until taken
   always_ff @(posedge clock) begin
      if (state_ff == ST_SEARCH && (&lane_done)) begin
         for (int i = 0; i < LaneCount; i++) begin
            rsp_data_ff[i*ByteW +: ByteW] <= lane_norm[i];
         end
         rsp_last_ff <= (count_ff == CntW'(VECTOR_WORDS - 1));
      end
   end

   l2n_ram #(
      .WIDTH (WordW),
      .DEPTH (VECTOR_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (count_ff[AddrW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (count_ff[AddrW-1:0]),
      .rd_data (rd_data)
   );

   for (genvar g = 0; g < LaneCount; g++) begin : g_lane
      assign lane_cmd[g].start   = lanes_start;
      assign lane_cmd[g].element = rd_data[g*ByteW +: ByteW];
      l2n_lane #(
         .SUM_W (SumW)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .cmd        (lane_cmd[g]),
         .square_sum (sum_ff),
         .done       (lane_done[g]),
         .norm       (lane_norm[g])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_ff) |=> (sum_ff == '0 && count_ff == '0))
      else $error("sum or count not cleared after last response");

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_last_ff == (count_ff == CntW'(VECTOR_WORDS - 1))))
      else $error("last flag out of step with word count");

   a_start_after_read: assert property (@(posedge clock) disable iff (reset)
      lanes_start |-> $past(rd_en))
      else $error("lanes started without a store read");
`endif

endmodule

### design/l2n_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module l2n_ram #(
   parameter int unsigned WIDTH  = 32,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/l2n_lane.sv
// One lane of the normalizer: bitwise search for k with k*k*S <= 16384*m*m.
// Depends on l2n_pkg.
module l2n_lane
   import l2n_pkg::*;
#(
   parameter int unsigned SUM_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  lane_cmd_type     cmd,
   input  logic [SUM_W-1:0] square_sum,
   output logic             done,
   output logic [ByteW-1:0] norm
);

   localparam int unsigned ProdW = SqW + SUM_W;

   phase_type          phase_ff, phase_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [2:0]         bit_ff, bit_in;
   logic [KeyW-1:0]    k_ff, k_in;
   logic               eq_ff, eq_in;
   logic               neg_ff, zero_ff;
   logic [TargetW-1:0] target_ff;
   logic [SqW-1:0]     sq_ff;
   logic [ProdW-1:0]   prod_ff;
   logic [KeyW-1:0]    trial;
   logic [ByteW:0]     mag;
   logic [KeyW:0]      ceil_k;
   logic [KeyW:0]      neg_byte;

   assign trial = k_ff | (KeyW'(1) << bit_ff);
   assign mag   = cmd.element[ByteW-1] ? (9'd0 - {1'b1, cmd.element})
                                       : {1'b0, cmd.element};

   // control: phase, bit index, running key and exact-match flag
   always_comb begin
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      bit_in   = bit_ff;
      k_in     = k_ff;
      eq_in    = eq_ff;
      if (cmd.start) begin
         phase_in = PH_SQUARE;
         busy_in  = 1'b1;
         done_in  = 1'b0;
         bit_in   = 3'd7;
         k_in     = '0;
         eq_in    = 1'b0;
      end else if (busy_ff) begin
         unique case (phase_ff)
            PH_SQUARE: phase_in = PH_SCALE;
            PH_SCALE:  phase_in = PH_COMPARE;
            PH_COMPARE: begin
               phase_in = PH_SQUARE;
               if (prod_ff <= ProdW'(target_ff)) begin
                  k_in  = trial;
                  eq_in = (prod_ff == ProdW'(target_ff));
               end
               if (bit_ff == 3'd0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  bit_in = bit_ff - 3'd1;
               end
            end
            default: phase_in = PH_SQUARE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SQUARE;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   // datapath: operands, square, scale by the sum
   always_ff @(posedge clock) begin
      bit_ff  <= bit_in;
      k_ff    <= k_in;
      eq_ff   <= eq_in;
      if (cmd.start) begin
         neg_ff    <= cmd.element[ByteW-1];
         zero_ff   <= (cmd.element == '0) || (square_sum == '0);
         target_ff <= TargetW'(mag * mag) << ScaleShift;
      end
      if (phase_ff == PH_SQUARE) begin
         sq_ff <= SqW'(trial * trial);
      end
      if (phase_ff == PH_SCALE) begin
         prod_ff <= ProdW'(sq_ff) * ProdW'(square_sum);
      end
   end

   // floor for positive, 256 - ceil for negative
   assign ceil_k   = eq_ff ? {1'b0, k_ff} : ({1'b0, k_ff} + 9'd1);
   assign neg_byte = 9'd0 - ceil_k;
   assign norm = zero_ff ? '0 : (neg_ff ? neg_byte[ByteW-1:0] : k_ff);
   assign done = done_ff;

endmodule
